// ===== sv/khud_pkg.sv =====
// Package for the keyed hash uniform draw: constants, micro-op codes, the
// control word and struct types, and the microcode program table.
// Depends on nothing; used by khud_datapath and keyed_hash_uniform_draw.
package khud_pkg;

  localparam int unsigned WordW  = 64;
  localparam int unsigned HalfW  = 32;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned FracW  = 53;
  localparam int unsigned PcW    = 4;
  localparam int unsigned CntW   = 3;

  localparam logic [WordW-1:0] FnvBasis = 64'hCBF29CE484222325;
  localparam logic [WordW-1:0] SmGamma  = 64'h9E3779B97F4A7C15;
  localparam logic [WordW-1:0] SmMul1   = 64'hBF58476D1CE4E5B9;
  localparam logic [WordW-1:0] SmMul2   = 64'h94D049BB133111EB;

  localparam logic [CntW-1:0] LastSeedByte = 3'd7;
  localparam logic [CntW-1:0] LastRound    = 3'd3;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_FOLD_ROLE,
    OP_FOLD_SEED,
    OP_KEY_GAMMA,
    OP_XSH30,
    OP_XSH27,
    OP_XSH31,
    OP_MUL_LL,
    OP_MUL_LH,
    OP_MUL_HL,
    OP_EMIT
  } op_e;

  typedef enum logic [1:0] {
    JMP_NONE,
    JMP_BYTES,
    JMP_ROUNDS
  } jmp_e;

  typedef struct packed {
    op_e            op;
    logic           mul_sel;
    jmp_e           jmp;
    logic [PcW-1:0] target;
    logic           last;
  } ucode_t;

  typedef struct packed {
    logic en;
    op_e  op;
    logic mul_sel;
  } ctrl_t;

  localparam logic [PcW-1:0] PcRole  = 4'd0;
  localparam logic [PcW-1:0] PcDraw  = 4'd1;
  localparam logic [PcW-1:0] PcRound = 4'd2;
  localparam logic [PcW-1:0] PcEmit  = 4'd12;

  // Role bytes run the single step at PcRole; a draw folds the seed bytes in
  // a loop, then runs four splitmix rounds and finally emits the result.
  function automatic ucode_t ucode_rom(input logic [PcW-1:0] pc);
    ucode_t w;
    w = '{op: OP_NOP, mul_sel: 1'b0, jmp: JMP_NONE, target: PcRole, last: 1'b1};
    unique case (pc)
      4'd0:  w = '{OP_FOLD_ROLE, 1'b0, JMP_NONE,   PcRole,  1'b1};
      4'd1:  w = '{OP_FOLD_SEED, 1'b0, JMP_BYTES,  PcDraw,  1'b0};
      4'd2:  w = '{OP_KEY_GAMMA, 1'b0, JMP_NONE,   PcRole,  1'b0};
      4'd3:  w = '{OP_XSH30,     1'b0, JMP_NONE,   PcRole,  1'b0};
      4'd4:  w = '{OP_MUL_LL,    1'b0, JMP_NONE,   PcRole,  1'b0};
      4'd5:  w = '{OP_MUL_LH,    1'b0, JMP_NONE,   PcRole,  1'b0};
      4'd6:  w = '{OP_MUL_HL,    1'b0, JMP_NONE,   PcRole,  1'b0};
      4'd7:  w = '{OP_XSH27,     1'b1, JMP_NONE,   PcRole,  1'b0};
      4'd8:  w = '{OP_MUL_LL,    1'b1, JMP_NONE,   PcRole,  1'b0};
      4'd9:  w = '{OP_MUL_LH,    1'b1, JMP_NONE,   PcRole,  1'b0};
      4'd10: w = '{OP_MUL_HL,    1'b1, JMP_NONE,   PcRole,  1'b0};
      4'd11: w = '{OP_XSH31,     1'b0, JMP_ROUNDS, PcRound, 1'b0};
      4'd12: w = '{OP_EMIT,      1'b0, JMP_NONE,   PcRole,  1'b1};
      default: w = '{OP_NOP,     1'b0, JMP_NONE,   PcRole,  1'b1};
    endcase
    return w;
  endfunction

  // Byte XOR, then multiply by the FNV prime 2^40 + 0x1B3 as shifts and adds.
  function automatic logic [WordW-1:0] fnv_fold(input logic [WordW-1:0] h,
                                                input logic [ByteW-1:0] b);
    logic [WordW-1:0] x;
    x = h ^ {{(WordW-ByteW){1'b0}}, b};
    return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
  endfunction

endpackage

// ===== sv/khud_datapath.sv =====
// Datapath of the keyed hash uniform draw: the hash register, the partial
// product register and one shared 32x32 multiplier, steered by control words.
// Depends on khud_pkg.
module khud_datapath (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  khud_pkg::ctrl_t             ctrl_i,
  input  logic [khud_pkg::ByteW-1:0]  role_byte_i,
  input  logic [khud_pkg::ByteW-1:0]  seed_byte_i,
  input  logic [khud_pkg::WordW-1:0]  key_i,
  output logic [khud_pkg::WordW-1:0]  hash_o
);

  logic [khud_pkg::WordW-1:0] hash_q, hash_d;
  logic [khud_pkg::WordW-1:0] prod_q, prod_d;
  logic [khud_pkg::WordW-1:0] mul_const;
  logic [khud_pkg::HalfW-1:0] mul_a, mul_b;
  logic [khud_pkg::WordW-1:0] mul_p;
  logic [khud_pkg::WordW-1:0] mul_shifted;

  assign mul_const   = ctrl_i.mul_sel ? khud_pkg::SmMul2 : khud_pkg::SmMul1;
  assign mul_p       = khud_pkg::WordW'(mul_a) * khud_pkg::WordW'(mul_b);
  assign mul_shifted = {mul_p[khud_pkg::HalfW-1:0], {khud_pkg::HalfW{1'b0}}};

  always_comb begin
    mul_a = hash_q[khud_pkg::HalfW-1:0];
    mul_b = mul_const[khud_pkg::HalfW-1:0];
    unique case (ctrl_i.op)
      khud_pkg::OP_MUL_LH: begin
        mul_b = mul_const[khud_pkg::WordW-1:khud_pkg::HalfW];
      end
      khud_pkg::OP_MUL_HL: begin
        mul_a = hash_q[khud_pkg::WordW-1:khud_pkg::HalfW];
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    hash_d = hash_q;
    prod_d = prod_q;
    if (ctrl_i.en) begin
      unique case (ctrl_i.op)
        khud_pkg::OP_FOLD_ROLE: hash_d = khud_pkg::fnv_fold(hash_q, role_byte_i);
        khud_pkg::OP_FOLD_SEED: hash_d = khud_pkg::fnv_fold(hash_q, seed_byte_i);
        khud_pkg::OP_KEY_GAMMA: hash_d = (hash_q ^ key_i) + khud_pkg::SmGamma;
        khud_pkg::OP_XSH30:     hash_d = hash_q ^ (hash_q >> 30);
        khud_pkg::OP_XSH27:     hash_d = hash_q ^ (hash_q >> 27);
        khud_pkg::OP_XSH31:     hash_d = hash_q ^ (hash_q >> 31);
        khud_pkg::OP_MUL_LL:    prod_d = mul_p;
        khud_pkg::OP_MUL_LH:    prod_d = prod_q + mul_shifted;
        khud_pkg::OP_MUL_HL:    hash_d = prod_q + mul_shifted;
        khud_pkg::OP_EMIT:      hash_d = khud_pkg::FnvBasis;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_q <= khud_pkg::FnvBasis;
    end else begin
      hash_q <= hash_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  assign hash_o = hash_q;

endmodule

// ===== sv/keyed_hash_uniform_draw.sv =====
// Top level of the keyed hash uniform draw: request handshakes, seed register,
// key registers, microcode sequencer and result register.
// Depends on khud_pkg and khud_datapath.
//
//   Channel  Direction  Handshake             Payload
//   in       input      in_valid_i/in_stall_o  kind, role_byte, key_a..key_d
//   out      output     out_valid_o/out_stall_i fraction
//   cfg      input      cfg_we_i               cfg_wdata_i (seed)
//
// A role byte request keeps the block busy for its fold step after acceptance,
// and no new request is taken until that step is done. A draw runs 49 program
// steps: eight seed byte folds, four rounds of ten steps and one emit step;
// each 64-bit multiply takes three steps through the shared 32x32 multiplier.
// Reset sets the hash to the FNV offset basis and the seed to zero.
// The emit step waits while an earlier result is still held and stalled.
module keyed_hash_uniform_draw (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        kind_i,
  input  logic [khud_pkg::ByteW-1:0]  role_byte_i,
  input  logic [khud_pkg::WordW-1:0]  key_a_i,
  input  logic [khud_pkg::WordW-1:0]  key_b_i,
  input  logic [khud_pkg::WordW-1:0]  key_c_i,
  input  logic [khud_pkg::WordW-1:0]  key_d_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [khud_pkg::FracW-1:0]  fraction_o,
  input  logic                        cfg_we_i,
  input  logic [khud_pkg::WordW-1:0]  cfg_wdata_i
);

  logic                        busy_q, busy_d;
  logic [khud_pkg::PcW-1:0]    pc_q, pc_d;
  logic [khud_pkg::CntW-1:0]   cnt_q, cnt_d;
  logic [khud_pkg::WordW-1:0]  seed_q;
  logic [khud_pkg::WordW-1:0]  key_a_q, key_b_q, key_c_q, key_d_q;
  logic [khud_pkg::ByteW-1:0]  role_byte_q;
  logic                        out_valid_q;
  logic [khud_pkg::FracW-1:0]  fraction_q;
  khud_pkg::ucode_t            uword;
  khud_pkg::ctrl_t             ctrl;
  logic                        in_accept;
  logic                        step_fire;
  logic                        emit_fire;
  logic                        jump_taken;
  logic [khud_pkg::WordW-1:0]  key_sel;
  logic [khud_pkg::ByteW-1:0]  seed_byte;
  logic [khud_pkg::WordW-1:0]  hash;

  assign in_accept = in_valid_i && !busy_q;
  assign in_stall_o = busy_q;

  assign uword     = khud_pkg::ucode_rom(pc_q);
  assign step_fire = busy_q && !(uword.op == khud_pkg::OP_EMIT && out_valid_q && out_stall_i);
  assign emit_fire = step_fire && (uword.op == khud_pkg::OP_EMIT);

  assign ctrl.en      = step_fire;
  assign ctrl.op      = uword.op;
  assign ctrl.mul_sel = uword.mul_sel;

  always_comb begin
    unique case (cnt_q[1:0])
      2'd0: key_sel = key_a_q;
      2'd1: key_sel = key_b_q;
      2'd2: key_sel = key_c_q;
      2'd3: key_sel = key_d_q;
      default: key_sel = key_a_q;
    endcase
  end

  assign seed_byte = seed_q[cnt_q*khud_pkg::ByteW +: khud_pkg::ByteW];

  always_comb begin
    jump_taken = 1'b0;
    cnt_d      = cnt_q;
    unique case (uword.jmp)
      khud_pkg::JMP_BYTES: begin
        jump_taken = (cnt_q != khud_pkg::LastSeedByte);
        cnt_d      = jump_taken ? cnt_q + 1'b1 : '0;
      end
      khud_pkg::JMP_ROUNDS: begin
        jump_taken = (cnt_q != khud_pkg::LastRound);
        cnt_d      = jump_taken ? cnt_q + 1'b1 : '0;
      end
      default: begin
      end
    endcase
    busy_d = busy_q;
    pc_d   = pc_q;
    if (!step_fire) begin
      cnt_d = cnt_q;
    end
    if (in_accept) begin
      busy_d = 1'b1;
      pc_d   = kind_i ? khud_pkg::PcDraw : khud_pkg::PcRole;
    end else if (step_fire) begin
      if (jump_taken) begin
        pc_d = uword.target;
      end else if (uword.last) begin
        busy_d = 1'b0;
      end else begin
        pc_d = pc_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      pc_q        <= khud_pkg::PcRole;
      cnt_q       <= '0;
      seed_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      pc_q   <= pc_d;
      cnt_q  <= cnt_d;
      if (cfg_we_i) begin
        seed_q <= cfg_wdata_i;
      end
      if (emit_fire) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      role_byte_q <= role_byte_i;
      key_a_q     <= key_a_i;
      key_b_q     <= key_b_i;
      key_c_q     <= key_c_i;
      key_d_q     <= key_d_i;
    end
    if (emit_fire) begin
      fraction_q <= hash[khud_pkg::WordW-1 -: khud_pkg::FracW];
    end
  end

  khud_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .role_byte_i (role_byte_q),
    .seed_byte_i (seed_byte),
    .key_i       (key_sel),
    .hash_o      (hash)
  );

  assign out_valid_o = out_valid_q;
  assign fraction_o  = fraction_q;

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_q |-> (cnt_q == '0))
    else $error("step counter not cleared while idle");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (pc_q <= khud_pkg::PcEmit))
    else $error("program counter beyond the program");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_fire |=> (out_valid_q && !busy_q))
    else $error("emit step did not present a result and finish");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_fire |-> (!out_valid_q || !out_stall_i))
    else $error("result overwritten while stalled");
`endif

endmodule
